@@ design/psd_pkg.sv @@
`default_nettype none
package psd_pkg;
	// coordinate width and derived widths
	localparam int unsigned CW   = 16;
	localparam int unsigned DW   = CW + 1;        // coordinate difference, signed
	localparam int unsigned PW   = 2 * DW;        // signed product of two differences
	localparam int unsigned DTW  = PW + 1;        // dot / cross sum, signed
	localparam int unsigned SQW  = 2 * CW;        // one square, unsigned
	localparam int unsigned SW   = SQW + 1;       // sum of two squares, |cross|
	localparam int unsigned LOW  = (SW + 1) / 2;  // low half of |cross|
	localparam int unsigned HIW  = SW - LOW;      // high half of |cross|
	localparam int unsigned NW   = 2 * SW;        // numerator width
	localparam int unsigned QW   = SW;            // quotient width
	localparam int unsigned RW   = CW + 1;        // root width
	localparam int unsigned TW   = 2 * RW + 1;    // sqrt trial width

	typedef enum logic [1:0] {
		PART_DEGEN    = 2'd0,
		PART_A        = 2'd1,
		PART_INTERIOR = 2'd2,
		PART_B        = 2'd3
	} part_t;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
	} in_t;

	// squared distance as a fraction num / den
	typedef struct packed {
		logic [NW-1:0] num;
		logic [SW-1:0] den;
		part_t         part;
	} frac_t;

	typedef struct packed {
		logic [SW-1:0] rem;
		logic [QW-1:0] low;
		logic [SW-1:0] den;
		part_t         part;
	} div_st_t;

	typedef struct packed {
		logic [QW-1:0] q;
		part_t         part;
	} quo_t;

	typedef struct packed {
		logic [SW-1:0] rem;
		logic [RW-1:0] root;
		part_t         part;
	} sqrt_st_t;
endpackage
`default_nettype wire

@@ design/psd_in_if.sv @@
`default_nettype none
interface psd_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [psd_pkg::CW-1:0] ax;
	logic signed [psd_pkg::CW-1:0] ay;
	logic signed [psd_pkg::CW-1:0] bx;
	logic signed [psd_pkg::CW-1:0] by;
	logic signed [psd_pkg::CW-1:0] px;
	logic signed [psd_pkg::CW-1:0] py;
	modport source (output valid, ax, ay, bx, by, px, py, input ready);
	modport sink (input valid, ax, ay, bx, by, px, py, output ready);
endinterface
`default_nettype wire

@@ design/psd_out_if.sv @@
`default_nettype none
interface psd_out_if;
	logic                   valid;
	logic                   ready;
	logic [psd_pkg::RW-1:0] dist_res;
	logic [1:0]             nearest_part;
	modport source (output valid, dist_res, nearest_part, input ready);
	modport sink (input valid, dist_res, nearest_part, output ready);
endinterface
`default_nettype wire

@@ design/psd_front.sv @@
`default_nettype none
// six stages: differences, products, sums, case select, |cross| square halves, num/den
module psd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire psd_pkg::in_t   d_in,
	input  wire logic           v_in,
	output logic                rdy_in,
	output psd_pkg::frac_t      d_out,
	output logic                v_out,
	input  wire logic           rdy_out
);
	logic [6:1] v;
	logic [7:1] en;

	logic signed [psd_pkg::DW-1:0]  ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [psd_pkg::PW-1:0]  dtx_s2, dty_s2, cra_s2, crb_s2;
	logic signed [psd_pkg::PW-1:0]  lx_s2, ly_s2, ax2_s2, ay2_s2, bx2_s2, by2_s2;
	logic signed [psd_pkg::DTW-1:0] dot_s3, cross_s3;
	logic [psd_pkg::SW-1:0]         len2_s3, da_s3, db_s3;
	logic [psd_pkg::SW-1:0]         cabs_s4, endd_s4, len2_s4, endd_s5, len2_s5;
	psd_pkg::part_t                 part_s4, part_s5, part_s6;
	logic [2*psd_pkg::HIW-1:0]          hh_s5;
	logic [psd_pkg::HIW+psd_pkg::LOW-1:0] hl_s5;
	logic [2*psd_pkg::LOW-1:0]          ll_s5;
	logic [psd_pkg::NW-1:0]         num_s6;
	logic [psd_pkg::SW-1:0]         den_s6;

	logic signed [psd_pkg::DTW-1:0] cneg;
	psd_pkg::part_t                 part_c;

	// ready ripples back from the output, last stage first
	always_comb begin
		en[7] = rdy_out;
		for (int k = 6; k >= 1; k--) begin
			en[k] = ~v[k] | en[k+1];
		end
	end
	assign rdy_in = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= v_in;
			for (int k = 2; k <= 6; k++) begin
				if (en[k]) v[k] <= v[k-1];
			end
		end
	end

	always_comb begin
		cneg = -cross_s3;
		if (len2_s3 == '0) begin
			part_c = psd_pkg::PART_DEGEN;
		end else if (dot_s3[psd_pkg::DTW-1]) begin
			part_c = psd_pkg::PART_A;
		end else if (dot_s3 > $signed(psd_pkg::DTW'(len2_s3))) begin
			part_c = psd_pkg::PART_B;
		end else begin
			part_c = psd_pkg::PART_INTERIOR;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ux_s1 <= psd_pkg::DW'(d_in.bx) - psd_pkg::DW'(d_in.ax);
			uy_s1 <= psd_pkg::DW'(d_in.by) - psd_pkg::DW'(d_in.ay);
			vx_s1 <= psd_pkg::DW'(d_in.px) - psd_pkg::DW'(d_in.ax);
			vy_s1 <= psd_pkg::DW'(d_in.py) - psd_pkg::DW'(d_in.ay);
			wx_s1 <= psd_pkg::DW'(d_in.px) - psd_pkg::DW'(d_in.bx);
			wy_s1 <= psd_pkg::DW'(d_in.py) - psd_pkg::DW'(d_in.by);
		end
		if (en[2]) begin
			dtx_s2 <= ux_s1 * vx_s1;
			dty_s2 <= uy_s1 * vy_s1;
			cra_s2 <= ux_s1 * vy_s1;
			crb_s2 <= uy_s1 * vx_s1;
			lx_s2  <= ux_s1 * ux_s1;
			ly_s2  <= uy_s1 * uy_s1;
			ax2_s2 <= vx_s1 * vx_s1;
			ay2_s2 <= vy_s1 * vy_s1;
			bx2_s2 <= wx_s1 * wx_s1;
			by2_s2 <= wy_s1 * wy_s1;
		end
		if (en[3]) begin
			dot_s3   <= psd_pkg::DTW'(dtx_s2) + psd_pkg::DTW'(dty_s2);
			cross_s3 <= psd_pkg::DTW'(cra_s2) - psd_pkg::DTW'(crb_s2);
			// squares are non-negative and fit SQW bits
			len2_s3  <= {1'b0, lx_s2[psd_pkg::SQW-1:0]} + {1'b0, ly_s2[psd_pkg::SQW-1:0]};
			da_s3    <= {1'b0, ax2_s2[psd_pkg::SQW-1:0]} + {1'b0, ay2_s2[psd_pkg::SQW-1:0]};
			db_s3    <= {1'b0, bx2_s2[psd_pkg::SQW-1:0]} + {1'b0, by2_s2[psd_pkg::SQW-1:0]};
		end
		if (en[4]) begin
			cabs_s4 <= cross_s3[psd_pkg::DTW-1] ? cneg[psd_pkg::SW-1:0]
			                                    : cross_s3[psd_pkg::SW-1:0];
			endd_s4 <= (part_c == psd_pkg::PART_B) ? db_s3 : da_s3;
			len2_s4 <= len2_s3;
			part_s4 <= part_c;
		end
		if (en[5]) begin
			hh_s5   <= cabs_s4[psd_pkg::SW-1:psd_pkg::LOW] * cabs_s4[psd_pkg::SW-1:psd_pkg::LOW];
			hl_s5   <= cabs_s4[psd_pkg::SW-1:psd_pkg::LOW] * cabs_s4[psd_pkg::LOW-1:0];
			ll_s5   <= cabs_s4[psd_pkg::LOW-1:0] * cabs_s4[psd_pkg::LOW-1:0];
			endd_s5 <= endd_s4;
			len2_s5 <= len2_s4;
			part_s5 <= part_s4;
		end
		if (en[6]) begin
			if (part_s5 == psd_pkg::PART_INTERIOR) begin
				num_s6 <= (psd_pkg::NW'(hh_s5) << (2 * psd_pkg::LOW))
				        + (psd_pkg::NW'(hl_s5) << (psd_pkg::LOW + 1))
				        + psd_pkg::NW'(ll_s5);
				den_s6 <= len2_s5;
			end else begin
				num_s6 <= psd_pkg::NW'(endd_s5);
				den_s6 <= psd_pkg::SW'(1);
			end
			part_s6 <= part_s5;
		end
	end

	assign d_out.num  = num_s6;
	assign d_out.den  = den_s6;
	assign d_out.part = part_s6;
	assign v_out      = v[6];
endmodule
`default_nettype wire

@@ design/psd_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per stage
module psd_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire psd_pkg::frac_t d_in,
	input  wire logic           v_in,
	output logic                rdy_in,
	output psd_pkg::quo_t       d_out,
	output logic                v_out,
	input  wire logic           rdy_out
);
	localparam int unsigned NS = psd_pkg::QW;

	psd_pkg::div_st_t st_s [NS];
	psd_pkg::div_st_t cur [NS];
	logic [NS-1:0]    v_s;
	logic [NS-1:0]    vin;
	logic [NS:0]      en;

	assign en[NS] = rdy_out;
	assign rdy_in = en[0];
	// quotient is known below 2^QW, so the top numerator half starts as remainder
	assign cur[0].rem  = d_in.num[psd_pkg::NW-1:psd_pkg::QW];
	assign cur[0].low  = d_in.num[psd_pkg::QW-1:0];
	assign cur[0].den  = d_in.den;
	assign cur[0].part = d_in.part;
	assign vin[0]      = v_in;

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [psd_pkg::SW:0] t, dz, dif;
		logic                 ge;
		psd_pkg::div_st_t     nxt;

		if (k > 0) begin : g_link
			assign cur[k] = st_s[k-1];
			assign vin[k] = v_s[k-1];
		end

		assign en[k] = ~v_s[k] | en[k+1];

		always_comb begin
			t   = {cur[k].rem, cur[k].low[psd_pkg::QW-1]};
			dz  = {1'b0, cur[k].den};
			dif = t - dz;
			ge  = (t >= dz);
			nxt.rem  = ge ? dif[psd_pkg::SW-1:0] : t[psd_pkg::SW-1:0];
			nxt.low  = {cur[k].low[psd_pkg::QW-2:0], ge};
			nxt.den  = cur[k].den;
			nxt.part = cur[k].part;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) st_s[k] <= nxt;
		end
	end

	assign d_out.q    = st_s[NS-1].low;
	assign d_out.part = st_s[NS-1].part;
	assign v_out      = v_s[NS-1];
endmodule
`default_nettype wire

@@ design/psd_sqrt.sv @@
`default_nettype none
// integer square root, one root bit per stage
module psd_sqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire psd_pkg::quo_t d_in,
	input  wire logic          v_in,
	output logic               rdy_in,
	output psd_pkg::sqrt_st_t  d_out,
	output logic               v_out,
	input  wire logic          rdy_out
);
	localparam int unsigned NS = psd_pkg::RW;

	psd_pkg::sqrt_st_t st_s [NS];
	psd_pkg::sqrt_st_t cur [NS];
	logic [NS-1:0]     v_s;
	logic [NS-1:0]     vin;
	logic [NS:0]       en;

	assign en[NS] = rdy_out;
	assign rdy_in = en[0];
	assign cur[0].rem  = d_in.q;
	assign cur[0].root = '0;
	assign cur[0].part = d_in.part;
	assign vin[0]      = v_in;

	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam int unsigned B = NS - 1 - k;
		logic [psd_pkg::TW-1:0] trial, rz;
		logic                   ge;
		psd_pkg::sqrt_st_t      nxt;

		if (k > 0) begin : g_link
			assign cur[k] = st_s[k-1];
			assign vin[k] = v_s[k-1];
		end

		assign en[k] = ~v_s[k] | en[k+1];

		always_comb begin
			// (root + 2^B)^2 - root^2
			trial = (psd_pkg::TW'(cur[k].root) << (B + 1)) + (psd_pkg::TW'(1) << (2 * B));
			rz    = psd_pkg::TW'(cur[k].rem);
			ge    = (trial <= rz);
			nxt.rem  = ge ? (cur[k].rem - trial[psd_pkg::SW-1:0]) : cur[k].rem;
			nxt.root = ge ? (cur[k].root | (psd_pkg::RW'(1) << B)) : cur[k].root;
			nxt.part = cur[k].part;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) st_s[k] <= nxt;
		end
	end

	assign d_out = st_s[NS-1];
	assign v_out = v_s[NS-1];
endmodule
`default_nettype wire

@@ design/point_segment_distance.sv @@
// Pipeline: 56 stages from an accepted word to its result word (front, divide, root).
// Throughput: one word per cycle while the output is not stalled; each stage then takes a new word every cycle.
// Stalls only hold stages that are occupied, so bubbles are squeezed out.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none
module point_segment_distance (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psd_in_if.sink     req,
	psd_out_if.source  rsp
);
	// Pipeline outline:
	//   front  - differences U=B-A, V=P-A, W=P-B; products; dot, cross, |AB|^2;
	//            case pick; squared distance as num/den (den=1 for endpoint and degenerate
	//            cases, cross^2 / |AB|^2 for the interior case)
	//   div    - floor(num/den), one bit per stage; floor(sqrt(num/den)) equals
	//            floor(sqrt(floor(num/den))), so nothing is lost
	//   sqrt   - digit-by-digit root of the quotient, last stage is the output register
	psd_pkg::in_t      in_word;
	psd_pkg::frac_t    fr_d;
	psd_pkg::quo_t     dv_d;
	psd_pkg::sqrt_st_t sq_d;
	logic              fr_v, fr_rdy, dv_v, dv_rdy, sq_v;

	assign in_word.ax = req.ax;
	assign in_word.ay = req.ay;
	assign in_word.bx = req.bx;
	assign in_word.by = req.by;
	assign in_word.px = req.px;
	assign in_word.py = req.py;

	psd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.d_in    (in_word),
		.v_in    (req.valid),
		.rdy_in  (req.ready),
		.d_out   (fr_d),
		.v_out   (fr_v),
		.rdy_out (fr_rdy)
	);

	psd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.d_in    (fr_d),
		.v_in    (fr_v),
		.rdy_in  (fr_rdy),
		.d_out   (dv_d),
		.v_out   (dv_v),
		.rdy_out (dv_rdy)
	);

	psd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.d_in    (dv_d),
		.v_in    (dv_v),
		.rdy_in  (dv_rdy),
		.d_out   (sq_d),
		.v_out   (sq_v),
		.rdy_out (rsp.ready)
	);

	assign rsp.valid        = sq_v;
	assign rsp.dist_res     = sq_d.root;
	assign rsp.nearest_part = sq_d.part;

	// a ready sink never back-pressures the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ready |-> req.ready)
		else $error("input stalled while output is ready");

	// endpoint and degenerate cases divide by one
	a_den_one: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_v && fr_d.part != psd_pkg::PART_INTERIOR) |-> (fr_d.den == psd_pkg::SW'(1)))
		else $error("endpoint case with denominator other than one");

	// interior case never divides by zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(fr_v && fr_d.part == psd_pkg::PART_INTERIOR) |-> (fr_d.den != '0))
		else $error("interior case with zero segment length");

	// a held output word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(sq_d)))
		else $error("output word changed while stalled");
endmodule
`default_nettype wire
